/* hdl/sius_pkg.sv */
// shared types and constants for the sorted interval union set
`default_nettype none

package sius_pkg;

	localparam int MAX_SPANS_DEF  = 16;
	localparam int INDEX_BITS_DEF = 16;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHUP,
		ST_INS,
		ST_MERGE,
		ST_SHDN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic lt;
		logic le;
	} cmp_res_t;

endpackage

`default_nettype wire

/* hdl/sius_cmp.sv */
// shared compare unit: one less-than and one less-or-equal
`default_nettype none

module sius_cmp
	import sius_pkg::*;
#(
	parameter int WIDTH = INDEX_BITS_DEF
) (
	input  logic [WIDTH-1:0] op_a,
	input  logic [WIDTH-1:0] op_b,
	input  logic [WIDTH-1:0] op_c,
	input  logic [WIDTH-1:0] op_d,
	output cmp_res_t         res
);

	assign res.lt = (op_a < op_b);
	assign res.le = (op_c <= op_d);

endmodule

`default_nettype wire

/* hdl/sorted_interval_union_set.sv */
// sorted interval union set: span list memory, sequencer and output register
// an item is accepted only in idle; the stored list is walked one entry per cycle
// query: a scan pass over the stored list; clear and unused code go straight to the done state
// add: a scan pass, then a shift pass of the span memory through its single read and single
// write port; an add at a full list that overlaps no stored span is dropped after the scan pass
// a stalled output holds the sequencer in its done state until the previous result beat leaves
// arst_n empties the list and the output register; span memory content is not cleared
`default_nettype none

module sorted_interval_union_set
	import sius_pkg::*;
#(
	parameter int MAX_SPANS  = MAX_SPANS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// span_a, span_b, probe_index
	input  logic [((3*INDEX_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// hit, dropped, span_total
	output logic [((2+$clog2(MAX_SPANS+1)+7)/8)*8-1:0] m_tdata
);

	localparam int IB = INDEX_BITS;
	localparam int CW = $clog2(MAX_SPANS + 1);
	localparam int AW = $clog2(MAX_SPANS);
	localparam int OB = ((2 + CW + 7) / 8) * 8;
	localparam logic [CW-1:0] FULL = CW'(MAX_SPANS);

	state_t state_q, state_d;

	logic [1:0]    cmd_q, cmd_d;
	logic [IB-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [IB-1:0] mlo_q, mlo_d, mhi_q, mhi_d;
	logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
	logic [CW-1:0] before_q, before_d, ovl_q, ovl_d;
	logic [CW-1:0] idx_m1, before_p1;
	logic [AW-1:0] wa_q, wa_d;
	logic          pend_q, pend_d;
	logic          hit_q, hit_d, drop_q, drop_d;
	logic          load_out;

	logic          m_tvalid_q, out_hit_q, out_drop_q;
	logic [CW-1:0] out_cnt_q;

	logic [2*IB-1:0] mem_q [MAX_SPANS];
	logic [2*IB-1:0] rd_data_q, wr_data;
	logic [AW-1:0]   rd_addr, wr_addr;
	logic            rd_en, wr_en;

	logic [IB-1:0] in_a, in_b, in_p, e_lo, e_hi;
	logic [IB-1:0] op_a, op_b, op_c, op_d;
	logic [IB-1:0] new_lo, new_hi;
	cmp_res_t      cmp;

	assign in_a = s_tdata[IB-1:0];
	assign in_b = s_tdata[2*IB-1:IB];
	assign in_p = s_tdata[3*IB-1:2*IB];
	assign e_lo = rd_data_q[IB-1:0];
	assign e_hi = rd_data_q[2*IB-1:IB];

	assign idx_m1    = idx_q - 1'b1;
	assign before_p1 = before_q + 1'b1;

	// operand select for the shared compare unit
	always_comb begin
		op_a = e_hi;
		op_b = lo_q;
		op_c = e_lo;
		op_d = hi_q;
		case (state_q)
			ST_IDLE: begin
				op_a = in_b;
				op_b = in_a;
				op_c = in_b;
				op_d = in_a;
			end
			ST_MERGE: begin
				op_a = mlo_q;
				op_b = lo_q;
				op_c = hi_q;
				op_d = mhi_q;
			end
			default: ;
		endcase
	end

	sius_cmp #(
		.WIDTH(IB)
	) u_cmp (
		.op_a(op_a),
		.op_b(op_b),
		.op_c(op_c),
		.op_d(op_d),
		.res (cmp)
	);

	assign new_lo = cmp.lt ? mlo_q : lo_q;
	assign new_hi = cmp.le ? mhi_q : hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mlo_q    <= mlo_d;
		mhi_q    <= mhi_d;
		idx_q    <= idx_d;
		before_q <= before_d;
		ovl_q    <= ovl_d;
		wa_q     <= wa_d;
		hit_q    <= hit_d;
		drop_q   <= drop_d;
		if (load_out) begin
			out_hit_q  <= hit_q;
			out_drop_q <= drop_q;
			out_cnt_q  <= cnt_q;
		end
	end

	// span memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mlo_d    = mlo_q;
		mhi_d    = mhi_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		before_d = before_q;
		ovl_d    = ovl_q;
		wa_d     = wa_q;
		hit_d    = hit_q;
		drop_d   = drop_q;
		pend_d   = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = idx_q[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = wa_q;
		wr_data  = rd_data_q;
		load_out = 1'b0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd_d    = s_tuser;
					idx_d    = '0;
					before_d = '0;
					ovl_d    = '0;
					hit_d    = 1'b0;
					drop_d   = 1'b0;
					if (s_tuser == CMD_QUERY) begin
						lo_d = in_p;
						hi_d = in_p;
					end else begin
						lo_d = cmp.lt ? in_b : in_a;
						hi_d = cmp.lt ? in_a : in_b;
					end
					case (s_tuser) inside
						CMD_ADD, CMD_QUERY: state_d = ST_SCAN;
						CMD_CLEAR: begin
							cnt_d   = '0;
							state_d = ST_DONE;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (idx_q < cnt_q) begin
					rd_en  = 1'b1;
					idx_d  = idx_q + 1'b1;
					pend_d = 1'b1;
				end
				if (pend_q) begin
					if (cmd_q == CMD_QUERY) begin
						if (!cmp.lt && cmp.le) begin
							hit_d = 1'b1;
						end
					end else if (cmp.lt) begin
						before_d = before_p1;
					end else if (cmp.le) begin
						if (ovl_q == '0) begin
							mlo_d = e_lo;
						end
						mhi_d = e_hi;
						ovl_d = ovl_q + 1'b1;
					end
				end
				if (idx_q == cnt_q && !pend_q) begin
					if (cmd_q == CMD_QUERY) begin
						state_d = ST_DONE;
					end else if (ovl_q != '0) begin
						state_d = ST_MERGE;
					end else if (cnt_q == FULL) begin
						drop_d  = 1'b1;
						state_d = ST_DONE;
					end else begin
						wa_d    = cnt_q[AW-1:0];
						state_d = ST_SHUP;
					end
				end
			end
			// open a slot: move entries at and above the insert point up by one
			ST_SHUP: begin
				if (idx_q > before_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_m1[AW-1:0];
					idx_d   = idx_m1;
					pend_d  = 1'b1;
				end
				if (pend_q) begin
					wr_en = 1'b1;
					wa_d  = wa_q - 1'b1;
				end
				if (idx_q == before_q && !pend_q) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				wr_en   = 1'b1;
				wr_addr = before_q[AW-1:0];
				wr_data = {hi_q, lo_q};
				cnt_d   = cnt_q + 1'b1;
				state_d = ST_DONE;
			end
			ST_MERGE: begin
				wr_en   = 1'b1;
				wr_addr = before_q[AW-1:0];
				wr_data = {new_hi, new_lo};
				idx_d   = before_q + ovl_q;
				wa_d    = before_p1[AW-1:0];
				state_d = ST_SHDN;
			end
			// close the gap left by absorbed spans
			ST_SHDN: begin
				if (idx_q < cnt_q) begin
					rd_en  = 1'b1;
					idx_d  = idx_q + 1'b1;
					pend_d = 1'b1;
				end
				if (pend_q) begin
					wr_en = 1'b1;
					wa_d  = wa_q + 1'b1;
				end
				if (idx_q == cnt_q && !pend_q) begin
					cnt_d   = cnt_q - ovl_q + 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OB'({out_cnt_q, out_drop_q, out_hit_q});

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && drop_q) |-> (cnt_q == FULL))
		else $error("span dropped while list not full");

	a_hit_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(out_hit_q && out_drop_q))
		else $error("hit and dropped both set in one beat");

	a_scan_keeps_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> (cnt_q == $past(cnt_q)))
		else $error("span count changed during scan");

endmodule

`default_nettype wire
